/* rtl/core/smpq_pkg.sv */
`default_nettype none

package smpq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

    // Output field widths (fixed by the result format)
    localparam int OUT_ELEM_WIDTH = 32;
    localparam int OUT_PRIO_WIDTH = 16;
    localparam int OUT_CNT_WIDTH  = 5;
    localparam int STATUS_WIDTH   = 2;

    // Beat widths, rounded up to whole bytes
    localparam int S_DATA_BITS  = ELEM_WIDTH + PRIO_WIDTH;
    localparam int S_DATA_WIDTH = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = OUT_ELEM_WIDTH + OUT_PRIO_WIDTH + OUT_CNT_WIDTH + 1
                                  + STATUS_WIDTH;
    localparam int M_DATA_WIDTH = ((M_DATA_BITS + 7) / 8) * 8;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_DEQ_EMPTY = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic [ELEM_WIDTH-1:0] elem;
        logic [PRIO_WIDTH-1:0] prio;
    } entry_t;

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic deq_en;
    } cell_ctl_t;

endpackage : smpq_pkg

`default_nettype wire

/* rtl/core/smpq_cell.sv */
`default_nettype none

module smpq_cell
    import smpq_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occupied,
    input  wire entry_t    new_entry,
    input  wire entry_t    left_entry,
    input  wire logic      left_keep,
    input  wire entry_t    right_entry,
    output entry_t         entry,
    output entry_t         entry_next,
    output logic           keep
);

    entry_t entry_reg;

    // New entry goes behind this one when its priority is not smaller
    assign keep = occupied && (new_entry.prio >= entry_reg.prio);

    // Insert: hold, take the new entry, or take the left neighbour's.
    // Dequeue: take the right neighbour's.
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins_en) begin
            if (!keep) begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end else if (ctl.deq_en) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : smpq_cell

`default_nettype wire

/* rtl/core/stable_min_priority_queue_core.sv */
`default_nettype none

// Sorted priority queue of DEPTH entries built as a row of compare-and-shift
// cells. One enqueue or dequeue beat is taken per clock while s_tready is high:
// every cell compares the incoming priority with its own in parallel and the
// row shifts at once, so the rate is one beat per cycle unless the output is
// stalled, and the result beat appears on the cycle after acceptance from an
// output register. Entries of equal priority leave in arrival order. An enqueue
// on a full queue and a dequeue on an empty queue leave it unchanged and are
// flagged in the status field. No fill or clearing pass is needed after reset.
module stable_min_priority_queue_core
    import smpq_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // s_tdata: elem [31:0], prio [47:32]
    input  wire logic [S_DATA_WIDTH-1:0] s_tdata,
    // s_tuser: cmd
    input  wire logic                    s_tuser,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // m_tdata: front_elem [31:0], front_prio [47:32], count [52:48],
    //          is_empty [53], status [55:54]
    output logic [M_DATA_WIDTH-1:0]      m_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready
);

    logic [CNT_WIDTH-1:0]    count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_WIDTH-1:0] m_data_reg, m_data_next;

    logic      s_accept;
    cmd_t      cmd;
    entry_t    new_entry;
    cell_ctl_t ctl;
    status_t   status;
    logic      full;
    logic      empty;

    entry_t     cell_entry [DEPTH];
    entry_t     cell_next  [DEPTH];
    logic [DEPTH-1:0] cell_keep;
    logic [DEPTH-1:0] cell_occ;

    entry_t               front;
    logic [OUT_ELEM_WIDTH-1:0] out_elem;
    logic [OUT_PRIO_WIDTH-1:0] out_prio;
    logic [OUT_CNT_WIDTH-1:0]  out_cnt;
    logic                 out_empty;

    // Input beat decode
    assign s_tready       = !m_valid_reg || m_tready;
    assign s_accept       = s_tvalid && s_tready;
    assign cmd            = cmd_t'(s_tuser);
    assign new_entry.elem = s_tdata[ELEM_WIDTH-1:0];
    assign new_entry.prio = s_tdata[ELEM_WIDTH +: PRIO_WIDTH];

    assign full  = (count_reg == CNT_WIDTH'(DEPTH));
    assign empty = (count_reg == '0);

    // Shift control and status
    always_comb begin
        ctl.ins_en = 1'b0;
        ctl.deq_en = 1'b0;
        status     = STATUS_OK;
        count_next = count_reg;
        if (s_accept) begin
            unique case (cmd)
                CMD_ENQUEUE: begin
                    if (full) begin
                        status = STATUS_FULL;
                    end else begin
                        ctl.ins_en = 1'b1;
                        count_next = count_reg + CNT_WIDTH'(1);
                    end
                end
                CMD_DEQUEUE: begin
                    if (empty) begin
                        status = STATUS_DEQ_EMPTY;
                    end else begin
                        ctl.deq_en = 1'b1;
                        count_next = count_reg - CNT_WIDTH'(1);
                    end
                end
                default: begin
                    status = STATUS_OK;
                end
            endcase
        end
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            entry_t left_e;
            logic   left_k;
            entry_t right_e;

            assign cell_occ[gi] = (count_reg > CNT_WIDTH'(gi));

            if (gi == 0) begin : g_first
                assign left_e = new_entry;
                assign left_k = 1'b1;
            end else begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign right_e = cell_entry[gi];
            end else begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            smpq_cell u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .occupied    (cell_occ[gi]),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .entry_next  (cell_next[gi]),
                .keep        (cell_keep[gi])
            );
        end
    endgenerate

    // Result beat from the state after this step
    assign front     = cell_next[0];
    assign out_empty = (count_next == '0);
    assign out_elem  = out_empty ? '0 : OUT_ELEM_WIDTH'(front.elem);
    assign out_prio  = out_empty ? '0 : OUT_PRIO_WIDTH'(front.prio);
    assign out_cnt   = OUT_CNT_WIDTH'(count_next);

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_data_next  = M_DATA_WIDTH'({status, out_empty, out_cnt, out_prio, out_elem});
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_WIDTH'(DEPTH))
        else $error("entry count beyond depth");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.ins_en && ctl.deq_en))
        else $error("insert and dequeue in the same cycle");

    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_WIDTH'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
        else $error("front pair out of order");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins_en |=> (count_reg == $past(count_reg) + CNT_WIDTH'(1)))
        else $error("count not advanced on insert");

    a_deq_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && status == STATUS_DEQ_EMPTY) |=> (m_tvalid && m_tdata[53]))
        else $error("empty dequeue reported non-empty");

endmodule : stable_min_priority_queue_core

`default_nettype wire
